>>> src/sle_pkg.sv
`default_nettype none
package sle_pkg;

	// Request codes
	localparam logic [1:0] OP_INSERT  = 2'd0;
	localparam logic [1:0] OP_EXTRACT = 2'd1;
	localparam logic [1:0] OP_SEARCH  = 2'd2;

	localparam int DEF_CAPACITY = 16;
	localparam int KEY_W        = 32;
	localparam int COUNT_OUT_W  = 5;

	// Per-request shift command broadcast to every cell
	typedef struct packed {
		logic shift_in;   // insert: cells at or past the slot take from the left
		logic shift_out;  // extract: cells at or past the match take from the right
	} cell_ctrl_t;

endpackage
`default_nettype wire

>>> src/sle_cell.sv
`default_nettype none
module sle_cell
	import sle_pkg::*;
(
	input  wire logic                    clk,
	input  wire cell_ctrl_t              ctrl,
	input  wire logic signed [KEY_W-1:0] key,
	input  wire logic                    active,
	input  wire logic signed [KEY_W-1:0] left_entry,
	input  wire logic                    left_ge,
	input  wire logic signed [KEY_W-1:0] right_entry,
	output logic signed [KEY_W-1:0]      entry,
	output logic                         ge,
	output logic                         found
);

	logic signed [KEY_W-1:0] entry_q;

	// At or past the first stored key >= request key (empty cells count as past)
	always_comb begin
		ge    = !active || !(entry_q < key);
		found = ge && !left_ge && active && (entry_q == key);
	end

	// Insert shifts up from the left, extract shifts down from the right
	always_ff @(posedge clk) begin
		if (ctrl.shift_in && ge) begin
			entry_q <= left_ge ? left_entry : key;
		end else if (ctrl.shift_out && ge) begin
			entry_q <= right_entry;
		end
	end

	assign entry = entry_q;

endmodule
`default_nettype wire

>>> src/sorted_list_engine.sv
// Channel  | Signals                        | Direction
// ---------+--------------------------------+----------
// request  | in_valid, in_stall, req_type,  | in
//          | key                            |
// result   | out_valid, out_stall, hit,     | out
//          | status, entry_count            |
//
// Each request is first captured, then committed in a step in which every cell
// compares against the key in parallel and the row shifts by one place.
// One request is in work at a time; a result waiting in the output register
// does not block the next capture, only the commit step of the one after.
// Reset clears the entry count and handshake state; cell contents are not reset.
`default_nettype none
module sorted_list_engine
	import sle_pkg::*;
#(
	parameter int CAPACITY = DEF_CAPACITY
) (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    in_valid,
	output logic                         in_stall,
	input  wire logic [1:0]              req_type,
	input  wire logic signed [KEY_W-1:0] key,
	output logic                         out_valid,
	input  wire logic                    out_stall,
	output logic                         hit,
	output logic                         status,
	output logic [COUNT_OUT_W-1:0]       entry_count
);

	localparam int CW = $clog2(CAPACITY + 1);

	logic                    busy_q;
	logic [1:0]              op_q;
	logic signed [KEY_W-1:0] key_q;
	logic [CW-1:0]           n_q;
	logic                    out_valid_q;
	logic                    hit_q;
	logic                    status_q;
	logic [CW-1:0]           n_out_q;

	logic                    commit;
	logic                    full;
	logic                    found_any;
	logic [CW-1:0]           n_next;
	logic [CW+COUNT_OUT_W-1:0] cnt_ext;
	cell_ctrl_t              ctrl;

	logic signed [KEY_W-1:0] entry_v [CAPACITY];
	logic [CAPACITY-1:0]     ge_v;
	logic [CAPACITY-1:0]     found_v;

	// Capture a request while no other one is in work
	assign in_stall = busy_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
		end else if (in_valid && !in_stall) begin
			busy_q <= 1'b1;
		end else if (commit) begin
			busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			op_q  <= req_type;
			key_q <= key;
		end
	end

	// Commit once the output register can take the result
	always_comb begin
		commit         = busy_q && (!out_valid_q || !out_stall);
		full           = (n_q == CW'(CAPACITY));
		found_any      = |found_v;
		ctrl.shift_in  = commit && (op_q == OP_INSERT) && !full;
		ctrl.shift_out = commit && (op_q == OP_EXTRACT) && found_any;
		n_next         = n_q;
		if (ctrl.shift_in) begin
			n_next = n_q + CW'(1);
		end else if (ctrl.shift_out) begin
			n_next = n_q - CW'(1);
		end
	end

	// Row of cells
	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic signed [KEY_W-1:0] left_entry;
		logic                    left_ge;
		logic signed [KEY_W-1:0] right_entry;

		if (i == 0) begin : g_first
			assign left_entry = key_q;
			assign left_ge    = 1'b0;
		end else begin : g_mid
			assign left_entry = entry_v[i-1];
			assign left_ge    = ge_v[i-1];
		end

		if (i == CAPACITY - 1) begin : g_last
			assign right_entry = entry_v[i];
		end else begin : g_inner
			assign right_entry = entry_v[i+1];
		end

		sle_cell u_cell (
			.clk         (clk),
			.ctrl        (ctrl),
			.key         (key_q),
			.active      (CW'(i) < n_q),
			.left_entry  (left_entry),
			.left_ge     (left_ge),
			.right_entry (right_entry),
			.entry       (entry_v[i]),
			.ge          (ge_v[i]),
			.found       (found_v[i])
		);
	end

	// Count and output handshake
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			n_q         <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (commit) begin
				n_q         <= n_next;
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Result payload
	always_ff @(posedge clk) begin
		if (commit) begin
			hit_q    <= ((op_q == OP_EXTRACT) || (op_q == OP_SEARCH)) && found_any;
			status_q <= (op_q == OP_INSERT) && full;
			n_out_q  <= n_next;
		end
	end

	assign cnt_ext     = (CW + COUNT_OUT_W)'(n_out_q);
	assign out_valid   = out_valid_q;
	assign hit         = hit_q;
	assign status      = status_q;
	assign entry_count = cnt_ext[COUNT_OUT_W-1:0];

`ifndef NO_ASSERTIONS
	// Count never exceeds the row length
	assert property (@(posedge clk) disable iff (!arst_n) n_q <= CW'(CAPACITY))
		else $error("entry count above capacity");

	// At most one cell can be the first match
	assert property (@(posedge clk) disable iff (!arst_n) $onehot0(found_v))
		else $error("more than one first-match cell");

	// A captured request sets busy, so no other one is captured before it is committed
	assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> busy_q)
		else $error("request capture lost");

	// A dropped insert never reports a hit
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && status_q) |-> !hit_q)
		else $error("hit and full flag together");
`endif

endmodule
`default_nettype wire

>>> sim/tb.sv
`default_nettype none
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import sle_pkg::*;

	localparam int CAP        = DEF_CAPACITY;
	localparam int PHASE_REQS = 382;
	localparam int LONG_HOLD  = 80;
	localparam logic [1:0] OP_NONE = 2'd3;  // unused code: no operation

	typedef logic signed [KEY_W-1:0] key_t;

	typedef struct {
		logic                   hit;
		logic                   status;
		logic [COUNT_OUT_W-1:0] count;
	} list_answer_t;

	// Tracks the list contents and the answers still owed by the block
	class list_tracker;
		key_t         entries[CAP];
		int           fill;
		list_answer_t owed[$];
		int           errors;

		function new();
			fill = 0;
			errors = 0;
		endfunction

		// Apply one accepted request to the tracked list and queue its answer
		function void note_request(logic [1:0] op, key_t k);
			list_answer_t ans;
			int pos;
			ans.hit = 1'b0;
			ans.status = 1'b0;
			case (op)
				OP_INSERT: begin
					if (fill >= CAP) begin
						ans.status = 1'b1;
					end else begin
						pos = 0;
						while (pos < fill && entries[pos] < k) pos++;
						for (int i = fill; i > pos; i--) entries[i] = entries[i-1];
						entries[pos] = k;
						fill++;
					end
				end
				OP_EXTRACT: begin
					pos = 0;
					while (pos < fill && entries[pos] != k) pos++;
					if (pos < fill) begin
						for (int i = pos; i + 1 < fill; i++) entries[i] = entries[i+1];
						fill--;
						ans.hit = 1'b1;
					end
				end
				OP_SEARCH: begin
					for (int i = 0; i < fill; i++) begin
						if (entries[i] == k) ans.hit = 1'b1;
					end
				end
				default: ;
			endcase
			ans.count = COUNT_OUT_W'(fill);
			owed.push_back(ans);
		endfunction

		// Compare one accepted result with the oldest owed answer
		function void check_result(logic h, logic s, logic [COUNT_OUT_W-1:0] c);
			list_answer_t ans;
			if (owed.size() == 0) begin
				$error("result with nothing owed: hit=%0b status=%0b entry_count=%0d",
					h, s, c);
				errors++;
				return;
			end
			ans = owed.pop_front();
			if (h !== ans.hit) begin
				$error("hit: expected %0b, got %0b", ans.hit, h);
				errors++;
			end
			if (s !== ans.status) begin
				$error("status: expected %0b, got %0b", ans.status, s);
				errors++;
			end
			if (c !== ans.count) begin
				$error("entry_count: expected %0d, got %0d", ans.count, c);
				errors++;
			end
		endfunction

		function int waiting();
			return owed.size();
		endfunction

		// A key currently in the list, or a small one when empty
		function key_t stored_key();
			if (fill == 0) return key_t'($urandom_range(0, 12)) - 6;
			return entries[$urandom_range(0, fill - 1)];
		endfunction
	endclass

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   in_valid = 1'b0;
	logic                   in_stall;
	logic [1:0]             req_type = OP_INSERT;
	key_t                   key = '0;
	logic                   out_valid;
	logic                   out_stall = 1'b0;
	logic                   hit;
	logic                   status;
	logic [COUNT_OUT_W-1:0] entry_count;

	list_tracker tracker = new();
	int idle_pct = 0;
	int stall_pct = 0;
	int hold_left = 0;
	bit hold_req = 1'b0;

	sorted_list_engine #(.CAPACITY(CAP)) u_top (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.req_type    (req_type),
		.key         (key),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.hit         (hit),
		.status      (status),
		.entry_count (entry_count)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// Result side: random stall, or a long hold-off when asked
	always @(negedge clk) begin
		if (hold_left > 0) begin
			out_stall <= 1'b1;
			hold_left--;
		end else if (hold_req) begin
			hold_req = 1'b0;
			hold_left = LONG_HOLD - 1;
			out_stall <= 1'b1;
		end else begin
			out_stall <= ($urandom_range(0, 99) < stall_pct);
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			tracker.check_result(hit, status, entry_count);
	end

	// Entered and left at a falling edge; returns once the request is taken
	task automatic send_request(logic [1:0] op, key_t k);
		while ($urandom_range(0, 99) < idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		req_type <= op;
		key <= k;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		tracker.note_request(op, k);
		@(negedge clk);
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		@(negedge clk);
		while (tracker.waiting() != 0) @(negedge clk);
	endtask

	// Mostly a small pool so that duplicates and hits are common
	function automatic key_t random_key();
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 60) return key_t'($urandom_range(0, 12)) - 6;
		if (roll < 70) begin
			case ($urandom_range(0, 3))
				0: return 32'sh8000_0000;
				1: return 32'sh7fff_ffff;
				2: return '0;
				default: return '1;
			endcase
		end
		return key_t'($urandom());
	endfunction

	initial begin
		int   roll;
		bit   grow;
		key_t k;
		repeat (8) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed: extremes, duplicates, hits and misses, full list, unused code
		send_request(OP_INSERT, 32'sh8000_0000);
		send_request(OP_INSERT, 32'sh7fff_ffff);
		send_request(OP_INSERT, 0);
		send_request(OP_INSERT, 0);
		send_request(OP_INSERT, -1);
		send_request(OP_SEARCH, 0);
		send_request(OP_SEARCH, 5);
		send_request(OP_EXTRACT, 0);
		send_request(OP_EXTRACT, 5);
		send_request(OP_NONE, 32'sh5555_aaaa);
		for (int i = 0; i < 12; i++) send_request(OP_INSERT, key_t'(i % 6) - 3);
		send_request(OP_INSERT, 1);
		send_request(OP_SEARCH, 32'sh7fff_ffff);
		send_request(OP_NONE, 32'shaaaa_5555);
		wait_drained();

		// Random phases with different idle and stall rates
		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: begin idle_pct = 0;  stall_pct = 0;  end
				1: begin idle_pct = 46; stall_pct = 0;  end
				2: begin idle_pct = 0;  stall_pct = 46; end
				default: begin idle_pct = 33; stall_pct = 33; end
			endcase
			grow = 1'b1;
			for (int n = 0; n < PHASE_REQS; n++) begin
				if (n % 40 == 0) grow = 1'($urandom_range(0, 1));
				if (n == 50) hold_req = 1'b1;
				if (n == 200) wait_drained();
				roll = $urandom_range(0, 99);
				if (roll < 5) begin
					send_request(OP_NONE, random_key());
				end else if (roll < (grow ? 60 : 25)) begin
					send_request(OP_INSERT, random_key());
				end else if (roll < (grow ? 80 : 75)) begin
					k = ($urandom_range(0, 9) < 7) ? tracker.stored_key() : random_key();
					send_request(OP_EXTRACT, k);
				end else begin
					k = $urandom_range(0, 1) ? tracker.stored_key() : random_key();
					send_request(OP_SEARCH, k);
				end
			end
			wait_drained();
		end

		stall_pct = 0;
		repeat (10) @(negedge clk);
		if (tracker.errors == 0 && tracker.waiting() == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

	initial begin
		#2_000_000;
		$display("tb: failure");
		$finish;
	end

endmodule
`default_nettype wire

>>> sim.f
src/sle_pkg.sv
src/sle_cell.sv
src/sorted_list_engine.sv
sim/tb.sv
